[rtl/fsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight state detector package
// Word types, configuration register map and shared types for the detector.
// ----------------------------------------------------------------------------
package fsd_pkg;

    localparam int THRUST_W = 15;
    localparam int SPEED_W  = 16;
    localparam int ACCEL_W  = 16;
    localparam int HEIGHT_W = 24;

    localparam int MIN_THRUST_W = 14;
    localparam int MIN_SPEED_W  = 15;
    localparam int MIN_ACCEL_W  = 15;
    localparam int HOLD_W       = 8;
    localparam int GND_THRUST_W = 14;
    localparam int GND_HEIGHT_W = 23;

    localparam int ALOFT_CNT_W = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 23;

    localparam logic [MIN_THRUST_W-1:0] RST_MIN_THRUST = MIN_THRUST_W'(500);
    localparam logic [MIN_SPEED_W-1:0]  RST_MIN_SPEED  = MIN_SPEED_W'(200);
    localparam logic [MIN_ACCEL_W-1:0]  RST_MIN_ACCEL  = MIN_ACCEL_W'(2000);
    localparam logic [HOLD_W-1:0]       RST_HOLD       = HOLD_W'(20);
    localparam logic [GND_THRUST_W-1:0] RST_GND_THRUST = GND_THRUST_W'(3000);
    localparam logic [GND_HEIGHT_W-1:0] RST_GND_HEIGHT = GND_HEIGHT_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_THRUST = 3'd0,
        CFG_MIN_SPEED  = 3'd1,
        CFG_MIN_ACCEL  = 3'd2,
        CFG_HOLD       = 3'd3,
        CFG_GND_THRUST = 3'd4,
        CFG_GND_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [THRUST_W-1:0] thrust;
        logic signed [SPEED_W-1:0]  vert_speed;
        logic signed [ACCEL_W-1:0]  vert_accel;
        logic signed [HEIGHT_W-1:0] height;
        logic                       motor_run;
    } t_in_word;

    typedef struct packed {
        logic airborne;
        logic aloft;
    } t_out_word;

    typedef struct packed {
        logic [MIN_THRUST_W-1:0] min_thrust;
        logic [MIN_SPEED_W-1:0]  min_speed;
        logic [MIN_ACCEL_W-1:0]  min_accel;
        logic [HOLD_W-1:0]       hold_ticks;
        logic [GND_THRUST_W-1:0] ground_thrust;
        logic [GND_HEIGHT_W-1:0] ground_height;
    } t_cfg;

    // Per-tick decisions that the state tracker consumes.
    typedef struct packed {
        logic motor_run;
        logic thrust_high;
        logic landing_ok;
        logic ground_ok;
    } t_cond;

endpackage

[rtl/fsd_cond.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight state detector condition logic
// Saturating magnitudes and threshold compares for one registered word.
// ----------------------------------------------------------------------------
module fsd_cond (
    input  fsd_pkg::t_in_word i_word,
    input  fsd_pkg::t_cfg     i_cfg,
    output fsd_pkg::t_cond    o_cond
);
    import fsd_pkg::*;

    // Magnitude of a 16-bit two's complement value, saturated to 15 bits.
    function automatic logic [14:0] sat_abs(input logic [15:0] v);
        logic [15:0] mag;
        mag = v[15] ? (16'd0 - v) : v;
        return mag[15] ? 15'h7FFF : mag[14:0];
    endfunction

    logic [14:0]        w_spd_abs;
    logic [14:0]        w_acc_abs;
    logic signed [15:0] w_thr;
    logic               w_thr_gt_min;
    logic               w_thr_gt_gnd;
    logic               w_hgt_gt_gnd;

    assign w_spd_abs = sat_abs(i_word.vert_speed);
    assign w_acc_abs = sat_abs(i_word.vert_accel);
    assign w_thr     = {i_word.thrust[THRUST_W-1], i_word.thrust};

    assign w_thr_gt_min = w_thr > $signed({2'b00, i_cfg.min_thrust});
    assign w_thr_gt_gnd = w_thr > $signed({2'b00, i_cfg.ground_thrust});
    assign w_hgt_gt_gnd = i_word.height > $signed({1'b0, i_cfg.ground_height});

    assign o_cond.motor_run   = i_word.motor_run;
    assign o_cond.thrust_high = w_thr_gt_min;
    assign o_cond.landing_ok  = !w_thr_gt_min
                                && (w_spd_abs < i_cfg.min_speed)
                                && (w_acc_abs < i_cfg.min_accel);
    assign o_cond.ground_ok   = w_thr_gt_gnd && w_hgt_gt_gnd;

endmodule

[rtl/fsd_track.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight state detector state tracker
// In-flight and above-ground flags with their hold counters.
// ----------------------------------------------------------------------------
module fsd_track (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  fsd_pkg::t_cond    i_cond,
    input  logic [7:0]        i_hold_ticks,
    output fsd_pkg::t_out_word o_result
);
    import fsd_pkg::*;

    logic                   r_flying;
    logic [HOLD_W-1:0]      r_flight_cnt;
    logic                   r_aloft;
    logic [ALOFT_CNT_W-1:0] r_aloft_cnt;

    logic                   n_flying;
    logic [HOLD_W-1:0]      n_flight_cnt;
    logic                   n_aloft;
    logic [ALOFT_CNT_W-1:0] n_aloft_cnt;

    logic [HOLD_W-1:0]      w_hold;
    logic [HOLD_W-1:0]      w_fc_dec;
    logic [HOLD_W-1:0]      w_fc_inc;
    logic [ALOFT_CNT_W-1:0] w_ac_inc;

    // A hold of zero behaves as a hold of one.
    assign w_hold   = (i_hold_ticks == '0) ? HOLD_W'(1) : i_hold_ticks;
    assign w_fc_dec = r_flight_cnt - HOLD_W'(1);
    assign w_fc_inc = r_flight_cnt + HOLD_W'(1);
    assign w_ac_inc = r_aloft_cnt + ALOFT_CNT_W'(1);

    always_comb begin
        n_flying     = r_flying;
        n_flight_cnt = r_flight_cnt;
        if (r_flying) begin
            if (r_flight_cnt != '0) begin
                if (i_cond.landing_ok) begin
                    n_flight_cnt = w_fc_dec;
                    if (w_fc_dec == '0) begin
                        n_flying = 1'b0;
                    end
                end else begin
                    n_flight_cnt = w_hold;
                end
            end
        end else if ((r_flight_cnt < w_hold) && i_cond.motor_run) begin
            if (i_cond.thrust_high) begin
                n_flight_cnt = w_fc_inc;
                if (w_fc_inc == w_hold) begin
                    n_flying = 1'b1;
                end
            end else begin
                n_flight_cnt = '0;
            end
        end

        // Above-ground sees the flight flag as already updated for this tick.
        n_aloft     = r_aloft;
        n_aloft_cnt = r_aloft_cnt;
        if (r_aloft) begin
            if (!n_flying) begin
                n_aloft = 1'b0;
            end
        end else if (n_flying) begin
            if (i_cond.ground_ok) begin
                n_aloft_cnt = w_ac_inc;
                if (w_ac_inc > {1'b0, w_hold}) begin
                    n_aloft     = 1'b1;
                    n_aloft_cnt = '0;
                end
            end else begin
                n_aloft_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flying     <= 1'b0;
            r_flight_cnt <= '0;
            r_aloft      <= 1'b0;
            r_aloft_cnt  <= '0;
        end else if (i_adv) begin
            r_flying     <= n_flying;
            r_flight_cnt <= n_flight_cnt;
            r_aloft      <= n_aloft;
            r_aloft_cnt  <= n_aloft_cnt;
        end
    end

    assign o_result.airborne = n_flying;
    assign o_result.aloft    = n_aloft;

endmodule

[rtl/flight_state_detector.sv]
`timescale 1ns / 1ps
// Path: a word is held in the input register, then its result in the result register.
// Throughput: one word per cycle; the input register and the result register decouple
// the two sides, so a stalled result only blocks input once the input register is full.
// Reset: synchronous, active low; clears the flight state, both hold counters, the
// valid flags and loads the default threshold registers.
// ----------------------------------------------------------------------------
// Flight state detector
// Takeoff, landing and above-ground detection with hold counters, one word per tick.
// ----------------------------------------------------------------------------
module flight_state_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  fsd_pkg::t_in_word                 i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output fsd_pkg::t_out_word                o_out_word,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fsd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fsd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import fsd_pkg::*;

    // Threshold registers. The user writes only while the detector is idle; the block
    // does not enforce it. The port is always ready and writes apply at the next edge.
    t_cfg r_cfg;

    // Input stage: holds one accepted word until the tracker consumes it.
    logic     r_in_vld;
    t_in_word r_in_word;

    // Result stage: holds the flags computed for the word last consumed.
    logic      r_out_vld;
    t_out_word r_out_word;

    logic      w_in_acc;
    logic      w_adv;
    t_cond     w_cond;
    t_out_word w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_thrust    <= RST_MIN_THRUST;
            r_cfg.min_speed     <= RST_MIN_SPEED;
            r_cfg.min_accel     <= RST_MIN_ACCEL;
            r_cfg.hold_ticks    <= RST_HOLD;
            r_cfg.ground_thrust <= RST_GND_THRUST;
            r_cfg.ground_height <= RST_GND_HEIGHT;
        end else if (i_cfg_valid) begin
            // Indexes past the end of the register map are dropped.
            unique case (i_cfg_index)
                CFG_MIN_THRUST: r_cfg.min_thrust    <= i_cfg_data[MIN_THRUST_W-1:0];
                CFG_MIN_SPEED:  r_cfg.min_speed     <= i_cfg_data[MIN_SPEED_W-1:0];
                CFG_MIN_ACCEL:  r_cfg.min_accel     <= i_cfg_data[MIN_ACCEL_W-1:0];
                CFG_HOLD:       r_cfg.hold_ticks    <= i_cfg_data[HOLD_W-1:0];
                CFG_GND_THRUST: r_cfg.ground_thrust <= i_cfg_data[GND_THRUST_W-1:0];
                CFG_GND_HEIGHT: r_cfg.ground_height <= i_cfg_data[GND_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // The tracker consumes the buffered word whenever the result stage is
    // empty or its word is being taken in this cycle. The input side is ready
    // whenever its buffer is empty or being drained, so words stream at one
    // per cycle while the downstream side keeps up.
    assign w_adv      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_word <= i_in_word;
        end
    end

    fsd_cond u_cond (
        .i_word (r_in_word),
        .i_cfg  (r_cfg),
        .o_cond (w_cond)
    );

    fsd_track u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_cond       (w_cond),
        .i_hold_ticks (r_cfg.hold_ticks),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    // Above-ground can only be reported together with in-flight.
    a_aloft_needs_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.airborne || !o_out_word.aloft))
        else $error("aloft flag reported while not airborne");

    // A full input buffer only takes a new word when it is drained the same cycle.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_in_vld) |-> w_adv)
        else $error("buffered word overwritten before use");

    // A buffered word that cannot advance stays buffered.
    a_hold_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_adv) |=> r_in_vld)
        else $error("buffered word lost while stalled");

    // Every consumed word yields a result word at the next edge.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_out_valid)
        else $error("consumed word produced no result");

endmodule

[dv/flight_state_detector_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight state detector testbench
// Drives thrust, speed, acceleration, height and motor words through the
// detector under a range of threshold settings. A local model of the takeoff,
// landing and above-ground counters predicts each result word, and a
// scoreboard compares the in-flight and above-ground flags one by one.
// ----------------------------------------------------------------------------
module flight_state_detector_test;
    import fsd_pkg::*;

    localparam int THRUST_MAX     = 9600;
    localparam int SPEED_MAX      = 32767;
    localparam int HEIGHT_MAX     = 8388607;
    localparam int HEIGHT_MIN     = -8388608;
    // The longest quiet stretch in a correct run is a receiver stall run plus a
    // sender gap, so this limit leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 1000;

    typedef enum int {GEN_TAKEOFF, GEN_CLIMB, GEN_LAND, GEN_NOISE} t_gen_mode;

    // One row of the directed table: either a register write or an input word,
    // with an optional expected result typed in by hand.
    typedef struct {
        bit        is_write;
        t_cfg_idx  reg_idx;
        int        reg_val;
        t_in_word  word;
        bit        typed;
        t_out_word result;
    } t_step;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_word   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Thresholds as the detector should hold them.
    int thr_min    = int'(RST_MIN_THRUST);
    int speed_min  = int'(RST_MIN_SPEED);
    int accel_min  = int'(RST_MIN_ACCEL);
    int hold_ticks = int'(RST_HOLD);
    int gnd_thrust = int'(RST_GND_THRUST);
    int gnd_height = int'(RST_GND_HEIGHT);

    // Flight state as the detector should hold it.
    bit fl_flying      = 1'b0;
    int fl_count       = 0;
    bit fl_aloft       = 1'b0;
    int fl_aloft_count = 0;

    t_out_word flags_due[$];
    t_step     directed_steps[$];

    int       fail_count  = 0;
    int       idle_cycles = 0;
    int       burst_left  = 0;
    bit       calm        = 1'b0;
    bit [7:0] stall_step  = '0;
    bit [15:0] stall_pat  = 16'hFFFF;

    flight_state_detector u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(32'(hi - lo)));
    endfunction

    // Absolute value clipped to the largest positive 16 bit value, so that the
    // most negative speed or acceleration never counts as small.
    function automatic int clip_abs(int v);
        int a;
        a = (v < 0) ? -v : v;
        return (a > SPEED_MAX) ? SPEED_MAX : a;
    endfunction

    // Advances the flight state by one tick and returns the flags after it.
    function automatic t_out_word next_flight_flags(t_in_word w);
        int        thr;
        int        spd;
        int        acc;
        int        hgt;
        int        hold;
        t_out_word flags;
        thr  = int'(w.thrust);
        spd  = clip_abs(int'(w.vert_speed));
        acc  = clip_abs(int'(w.vert_accel));
        hgt  = int'(w.height);
        hold = (hold_ticks == 0) ? 1 : hold_ticks;

        // Landing countdown while flying; takeoff count-up on the ground. A
        // count already at or above the hold value on the ground stays frozen.
        if (fl_flying) begin
            if (fl_count > 0) begin
                if (thr <= thr_min && spd < speed_min && acc < accel_min) begin
                    fl_count--;
                    if (fl_count == 0) begin
                        fl_flying = 1'b0;
                    end
                end else begin
                    fl_count = hold;
                end
            end
        end else if (fl_count < hold && w.motor_run) begin
            if (thr > thr_min) begin
                fl_count++;
                if (fl_count == hold) begin
                    fl_flying = 1'b1;
                end
            end else begin
                fl_count = 0;
            end
        end
        fl_count &= 8'hFF;

        // Above-ground follows the flying flag of this very tick.
        if (fl_aloft) begin
            if (!fl_flying) begin
                fl_aloft = 1'b0;
            end
        end else if (fl_flying) begin
            if (thr > gnd_thrust && hgt > gnd_height) begin
                fl_aloft_count = (fl_aloft_count + 1) & 9'h1FF;
                if (fl_aloft_count > hold) begin
                    fl_aloft       = 1'b1;
                    fl_aloft_count = 0;
                end
            end else begin
                fl_aloft_count = 0;
            end
        end

        flags.airborne = fl_flying;
        flags.aloft    = fl_aloft;
        return flags;
    endfunction

    function automatic t_in_word pack_word(int thr, int spd, int acc, int hgt, bit mot);
        t_in_word w;
        w.thrust     = thr[THRUST_W-1:0];
        w.vert_speed = spd[SPEED_W-1:0];
        w.vert_accel = acc[ACCEL_W-1:0];
        w.height     = hgt[HEIGHT_W-1:0];
        w.motor_run  = mot;
        return w;
    endfunction

    // Builds one random word shaped to push the detector toward a given phase
    // of a flight; noise words are random over every field.
    function automatic t_in_word make_word(t_gen_mode mode);
        int thr;
        int spd;
        int acc;
        int hgt;
        bit mot;
        thr = rand_between(-THRUST_MAX, THRUST_MAX);
        spd = $urandom;
        acc = $urandom;
        hgt = $urandom;
        mot = 1'($urandom_range(1));
        case (mode)
            GEN_TAKEOFF: begin
                mot = 1'b1;
                if (thr_min < THRUST_MAX) begin
                    thr = rand_between(thr_min + 1, THRUST_MAX);
                end
            end
            GEN_CLIMB: begin
                mot = 1'b1;
                if (gnd_thrust < THRUST_MAX) begin
                    thr = rand_between(gnd_thrust + 1, THRUST_MAX);
                end
                if (gnd_height < HEIGHT_MAX) begin
                    hgt = rand_between(gnd_height + 1, HEIGHT_MAX);
                end
            end
            GEN_LAND: begin
                thr = rand_between(-THRUST_MAX, thr_min);
                if (speed_min > 0) begin
                    spd = rand_between(1 - speed_min, speed_min - 1);
                end
                if (accel_min > 0) begin
                    acc = rand_between(1 - accel_min, accel_min - 1);
                end
            end
            default: ;
        endcase
        return pack_word(thr, spd, acc, hgt, mot);
    endfunction

    function automatic void add_write(t_cfg_idx idx, int val);
        t_step s;
        s          = '{reg_idx: idx, default: '0};
        s.is_write = 1'b1;
        s.reg_val  = val;
        directed_steps.push_back(s);
    endfunction

    function automatic void add_word(int thr, int spd, int acc, int hgt, bit mot,
                                     bit typed = 1'b0, bit fl = 1'b0, bit ag = 1'b0);
        t_step s;
        s                 = '{reg_idx: CFG_MIN_THRUST, default: '0};
        s.word            = pack_word(thr, spd, acc, hgt, mot);
        s.typed           = typed;
        s.result.airborne = fl;
        s.result.aloft    = ag;
        directed_steps.push_back(s);
    endfunction

    function automatic void log_failure(string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    // Register writes happen only with the input side quiet and every result
    // word already collected.
    task automatic write_reg(t_cfg_idx idx, int val);
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
        end
        while (flags_due.size() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            CFG_MIN_THRUST: thr_min    = int'(val[MIN_THRUST_W-1:0]);
            CFG_MIN_SPEED:  speed_min  = int'(val[MIN_SPEED_W-1:0]);
            CFG_MIN_ACCEL:  accel_min  = int'(val[MIN_ACCEL_W-1:0]);
            CFG_HOLD:       hold_ticks = int'(val[HOLD_W-1:0]);
            CFG_GND_THRUST: gnd_thrust = int'(val[GND_THRUST_W-1:0]);
            CFG_GND_HEIGHT: gnd_height = int'(val[GND_HEIGHT_W-1:0]);
            default: ;
        endcase
    endtask

    // Sends one word in bursts with random gaps between them. The expected
    // flags are queued in the step of the accepting edge, so they are always
    // waiting before the matching result word can appear.
    task automatic send_word(t_in_word w, bit typed, t_out_word fixed);
        int        gap;
        t_out_word predicted;
        if (i_cfg_valid) begin
            i_cfg_valid <= 1'b0;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(40, 1);
            gap = (calm || $urandom_range(3) == 0) ? 0 : $urandom_range(5, 1);
            if (gap != 0) begin
                if (i_in_valid) begin
                    i_in_valid <= 1'b0;
                end
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        predicted = next_flight_flags(w);
        flags_due.push_back(typed ? fixed : predicted);
    endtask

    // The receiver follows a 16 bit ready pattern that is redrawn whenever the step
    // counter wraps; one bit is always set so no stall runs past a pattern length.
    always @(posedge i_clk) begin
        stall_step <= stall_step + 1'b1;
        if (stall_step == 8'hFF) begin
            stall_pat <= 16'($urandom | $urandom) | 16'h0001;
        end
        i_out_ready <= calm ? 1'b1 : stall_pat[stall_step[3:0]];
    end

    // Scoreboard: every result word is matched against the oldest prediction.
    always @(posedge i_clk) begin : scoreboard
        t_out_word due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (flags_due.size() == 0) begin
                log_failure($sformatf("result word %b with nothing expected", o_out_word));
            end else begin
                due = flags_due.pop_front();
                if (o_out_word.airborne !== due.airborne) begin
                    log_failure($sformatf("airborne expected %b got %b",
                                          due.airborne, o_out_word.airborne));
                end
                if (o_out_word.aloft !== due.aloft) begin
                    log_failure($sformatf("aloft expected %b got %b",
                                          due.aloft, o_out_word.aloft));
                end
            end
        end
    end

    // Ends a run that has stopped moving words on every channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_gen_mode mode;
        int        seg_left;
        int        phase_len;
        int        hold_eff;
        int        pick;
        int        set_thr;
        int        set_speed;
        int        set_accel;
        int        set_hold;
        int        set_gthr;
        int        set_ghgt;

        // Right after reset nothing can fly: motors off, or thrust at the floor.
        add_word(0, 0, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0);
        add_word(THRUST_MAX, -SPEED_MAX - 1, -SPEED_MAX - 1, HEIGHT_MAX, 1'b0,
                 1'b1, 1'b0, 1'b0);
        add_word(-THRUST_MAX, SPEED_MAX, SPEED_MAX, HEIGHT_MIN, 1'b1, 1'b1, 1'b0, 1'b0);
        // A zero hold behaves as a hold of one tick: immediate takeoff, then
        // above-ground after two qualifying ticks.
        add_write(CFG_HOLD, 0);
        add_word(501, 0, 0, 0, 1'b1);
        add_word(THRUST_MAX, 0, 0, HEIGHT_MAX, 1'b1);
        add_word(THRUST_MAX, 0, 0, HEIGHT_MAX, 1'b1);
        // The most negative speed and acceleration clip to the top value and
        // must block landing; then a clean landing clears both flags.
        add_word(500, -SPEED_MAX - 1, 0, 0, 1'b0);
        add_word(0, 0, -SPEED_MAX - 1, 0, 1'b0);
        add_word(-THRUST_MAX, -199, 1999, 0, 1'b0);
        // Lowering the hold under a partial takeoff count freezes the count
        // until the hold is raised above it again.
        add_write(CFG_HOLD, 20);
        repeat (5) add_word(THRUST_MAX, 0, 0, 0, 1'b1);
        add_write(CFG_HOLD, 3);
        repeat (2) add_word(THRUST_MAX, 0, 0, 0, 1'b1);
        add_write(CFG_HOLD, 6);
        add_word(THRUST_MAX, 0, 0, 0, 1'b1);
        // Lowering the hold in flight: the landing countdown resumes from the
        // old count, and a bad tick reloads it with the new hold.
        add_write(CFG_HOLD, 2);
        add_word(500, 199, -1999, 0, 1'b1);
        add_word(501, 0, 0, 0, 1'b1);
        add_word(-1, 0, 0, 0, 1'b0);
        add_word(-1, 0, 0, 0, 1'b0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[k]) begin
            if (directed_steps[k].is_write) begin
                write_reg(directed_steps[k].reg_idx, directed_steps[k].reg_val);
            end else begin
                send_word(directed_steps[k].word, directed_steps[k].typed,
                          directed_steps[k].result);
            end
        end

        // Random phases, each under its own thresholds: reset values, all
        // lows, all highs, a long run with the largest hold, then random ones.
        for (int phase = 0; phase < 14; phase++) begin
            calm <= (phase % 3 == 2);
            case (phase)
                0: begin
                    set_thr   = int'(RST_MIN_THRUST);
                    set_speed = int'(RST_MIN_SPEED);
                    set_accel = int'(RST_MIN_ACCEL);
                    set_hold  = int'(RST_HOLD);
                    set_gthr  = int'(RST_GND_THRUST);
                    set_ghgt  = int'(RST_GND_HEIGHT);
                end
                1: begin
                    set_thr   = 0;
                    set_speed = 0;
                    set_accel = 0;
                    set_hold  = 1;
                    set_gthr  = 0;
                    set_ghgt  = 0;
                end
                2: begin
                    set_thr   = THRUST_MAX;
                    set_speed = SPEED_MAX;
                    set_accel = SPEED_MAX;
                    set_hold  = 255;
                    set_gthr  = THRUST_MAX;
                    set_ghgt  = HEIGHT_MAX;
                end
                3: begin
                    set_thr   = 0;
                    set_speed = SPEED_MAX;
                    set_accel = SPEED_MAX;
                    set_hold  = 255;
                    set_gthr  = 0;
                    set_ghgt  = 0;
                end
                default: begin
                    set_thr   = rand_between(0, THRUST_MAX);
                    set_speed = rand_between(1, SPEED_MAX);
                    set_accel = rand_between(1, SPEED_MAX);
                    set_hold  = ($urandom_range(7) == 0) ? 0 : rand_between(1, 24);
                    set_gthr  = rand_between(0, THRUST_MAX);
                    set_ghgt  = rand_between(0, HEIGHT_MAX);
                end
            endcase
            write_reg(CFG_MIN_THRUST, set_thr);
            write_reg(CFG_MIN_SPEED, set_speed);
            write_reg(CFG_MIN_ACCEL, set_accel);
            write_reg(CFG_HOLD, set_hold);
            write_reg(CFG_GND_THRUST, set_gthr);
            write_reg(CFG_GND_HEIGHT, set_ghgt);

            // Mostly runs of words that should carry the flight forward, some
            // cut short to break the count, mixed with bursts of noise.
            phase_len = (phase == 3) ? 700 : 70;
            seg_left  = 0;
            mode      = GEN_NOISE;
            for (int n = 0; n < phase_len; n++) begin
                if (seg_left == 0) begin
                    hold_eff = (hold_ticks == 0) ? 1 : hold_ticks;
                    pick     = $urandom_range(9);
                    if (pick < 2) begin
                        mode     = GEN_NOISE;
                        seg_left = $urandom_range(4, 1);
                    end else begin
                        if (!fl_flying) begin
                            mode = GEN_TAKEOFF;
                        end else if (!fl_aloft && pick < 7) begin
                            mode = GEN_CLIMB;
                        end else begin
                            mode = GEN_LAND;
                        end
                        seg_left = ($urandom_range(3) == 0) ? $urandom_range(hold_eff, 1)
                                 : hold_eff + 1 + $urandom_range(3);
                    end
                end
                seg_left--;
                send_word(make_word(mode), 1'b0, '0);
            end
        end

        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (flags_due.size() != 0) begin
            @(posedge i_clk);
        end
        // Keep clocking to catch any stray result word.
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/fsd_pkg.sv
rtl/fsd_cond.sv
rtl/fsd_track.sv
rtl/flight_state_detector.sv
dv/flight_state_detector_test.sv
